// ----- rtl/core/bsbi_pkg.sv -----
// types and constants shared by the bounded stack with bottom increment
// no dependencies
package bsbi_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 11;
    localparam int KCNT_W = 16;
    localparam int REQ_W  = 2;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 11'd1024;
    localparam logic [DATA_W-1:0] EMPTY_WORD = 32'hFFFF_FFFF;

    localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_INCR = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } bsbi_state_t;

    typedef struct packed {
        logic accept;
        logic commit;
        logic load_out;
    } bsbi_cmd_t;

    typedef struct packed {
        logic pop_pending;
    } bsbi_status_t;

endpackage

// ----- rtl/core/bsbi_ctrl.sv -----
// controller for the bounded stack: request handshake, exec sequencing, output valid
// depends on bsbi_pkg
module bsbi_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  bsbi_pkg::bsbi_status_t status,
    output bsbi_pkg::bsbi_cmd_t    cmd
);

    bsbi_pkg::bsbi_state_t state_reg;
    bsbi_pkg::bsbi_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_blocked;
    logic                  can_commit;

    assign out_blocked = out_valid_reg && !m_tready;
    assign can_commit  = !(status.pop_pending && out_blocked);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bsbi_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = bsbi_pkg::ST_EXEC;
                end
            end
            bsbi_pkg::ST_EXEC:
            begin
                if (can_commit)
                begin
                    state_next = bsbi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bsbi_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.commit   = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            bsbi_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            bsbi_pkg::ST_EXEC:
            begin
                cmd.commit   = can_commit;
                cmd.load_out = can_commit && status.pop_pending;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bsbi_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ----- rtl/core/bsbi_datapath.sv -----
// datapath for the bounded stack: value and lazy-add memories, count, capacity, result
// depends on bsbi_pkg
module bsbi_datapath
#(
    parameter int STACK_DEPTH = 1024
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  bsbi_pkg::bsbi_cmd_t               cmd,
    output bsbi_pkg::bsbi_status_t            status,
    input  logic                              cfg_wen,
    input  logic [bsbi_pkg::CAP_W-1:0]        cfg_wdata,
    input  logic [bsbi_pkg::REQ_W-1:0]        req_type,
    input  logic signed [bsbi_pkg::DATA_W-1:0] push_value,
    input  logic [bsbi_pkg::KCNT_W-1:0]       bottom_count,
    input  logic signed [bsbi_pkg::DATA_W-1:0] add_amount,
    output logic signed [bsbi_pkg::DATA_W-1:0] popped_value,
    output logic                              was_empty
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CAPC_W = (CNT_W > bsbi_pkg::CAP_W) ? CNT_W : bsbi_pkg::CAP_W;
    localparam int KC_W   = (CNT_W > bsbi_pkg::KCNT_W) ? CNT_W : bsbi_pkg::KCNT_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

    logic [bsbi_pkg::DATA_W-1:0] val_mem  [STACK_DEPTH];
    logic [bsbi_pkg::DATA_W-1:0] lazy_mem [STACK_DEPTH];

    logic [bsbi_pkg::CAP_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;

    logic [bsbi_pkg::REQ_W-1:0]  req_type_reg;
    logic [bsbi_pkg::DATA_W-1:0] push_value_reg;
    logic [bsbi_pkg::DATA_W-1:0] add_amount_reg;
    logic                        push_ok_reg;
    logic                        empty_reg;
    logic                        has_below_reg;
    logic                        incr_ok_reg;
    logic [ADDR_W-1:0]           addr_a_reg;
    logic [ADDR_W-1:0]           addr_b_reg;
    logic [bsbi_pkg::DATA_W-1:0] val_rd_reg;
    logic [bsbi_pkg::DATA_W-1:0] lazy_a_rd_reg;
    logic [bsbi_pkg::DATA_W-1:0] lazy_b_rd_reg;
    logic [bsbi_pkg::DATA_W-1:0] popped_reg;
    logic                        was_empty_reg;

    logic [CNT_W-1:0]            cnt_m1;
    logic [CNT_W-1:0]            cnt_m2;
    logic [KC_W-1:0]             k_ext;
    logic [KC_W-1:0]             cnt_k_ext;
    logic [KC_W-1:0]             n_sel;
    logic [KC_W-1:0]             n_m1;
    logic                        push_ok;
    logic [ADDR_W-1:0]           rd_addr_a;
    logic [ADDR_W-1:0]           rd_addr_b;
    logic [bsbi_pkg::DATA_W-1:0] pop_sum;

    logic                        val_we;
    logic                        lazy_we;
    logic [ADDR_W-1:0]           lazy_wr_addr;
    logic [bsbi_pkg::DATA_W-1:0] lazy_wr_data;

    // request decode against the current count
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign cnt_m2    = count_reg - CNT_W'(2);
    assign k_ext     = KC_W'(bottom_count);
    assign cnt_k_ext = KC_W'(count_reg);
    assign n_sel     = (k_ext < cnt_k_ext) ? k_ext : cnt_k_ext;
    assign n_m1      = n_sel - KC_W'(1);
    assign push_ok   = (CAPC_W'(count_reg) < CAPC_W'(capacity_reg)) && (count_reg != DEPTH_CNT);
    assign rd_addr_a = (req_type == bsbi_pkg::REQ_POP) ? cnt_m1[ADDR_W-1:0] : n_m1[ADDR_W-1:0];
    assign rd_addr_b = cnt_m2[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_type_reg   <= req_type;
            push_value_reg <= push_value;
            add_amount_reg <= add_amount;
            push_ok_reg    <= push_ok;
            empty_reg      <= (count_reg == '0);
            has_below_reg  <= (count_reg > CNT_W'(1));
            incr_ok_reg    <= (n_sel != '0);
            addr_a_reg     <= rd_addr_a;
            addr_b_reg     <= rd_addr_b;
            val_rd_reg     <= val_mem[cnt_m1[ADDR_W-1:0]];
            lazy_a_rd_reg  <= lazy_mem[rd_addr_a];
            lazy_b_rd_reg  <= lazy_mem[rd_addr_b];
        end
    end

    assign pop_sum = val_rd_reg + lazy_a_rd_reg;

    always_comb
    begin
        val_we       = 1'b0;
        lazy_we      = 1'b0;
        lazy_wr_addr = addr_a_reg;
        lazy_wr_data = '0;
        count_next   = count_reg;
        case (req_type_reg)
            bsbi_pkg::REQ_PUSH:
            begin
                val_we       = cmd.commit && push_ok_reg;
                lazy_we      = cmd.commit && push_ok_reg;
                lazy_wr_addr = count_reg[ADDR_W-1:0];
                if (cmd.commit && push_ok_reg)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            bsbi_pkg::REQ_POP:
            begin
                // pending add of the top slot moves down one slot
                lazy_we      = cmd.commit && has_below_reg;
                lazy_wr_addr = addr_b_reg;
                lazy_wr_data = lazy_b_rd_reg + lazy_a_rd_reg;
                if (cmd.commit && !empty_reg)
                begin
                    count_next = cnt_m1;
                end
            end
            bsbi_pkg::REQ_INCR:
            begin
                lazy_we      = cmd.commit && incr_ok_reg;
                lazy_wr_addr = addr_a_reg;
                lazy_wr_data = lazy_a_rd_reg + add_amount_reg;
            end
            default:
            begin
                val_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[count_reg[ADDR_W-1:0]] <= push_value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lazy_we)
        begin
            lazy_mem[lazy_wr_addr] <= lazy_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            popped_reg    <= empty_reg ? bsbi_pkg::EMPTY_WORD : pop_sum;
            was_empty_reg <= empty_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            capacity_reg <= bsbi_pkg::CAP_RESET;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_wen)
            begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    assign status.pop_pending = (req_type_reg == bsbi_pkg::REQ_POP);
    assign popped_value       = popped_reg;
    assign was_empty          = was_empty_reg;

endmodule

// ----- rtl/core/bounded_stack_with_bottom_increment.sv -----
// top level of the bounded stack with bottom increment
// depends on bsbi_pkg, bsbi_ctrl, bsbi_datapath
//
// requests enter on the s_ stream: tuser carries the request kind (push, pop,
// increment bottom entries), tdata the push value, bottom count and add amount.
// only a pop produces a transaction on the m_ stream: tdata is the popped value,
// tuser flags a pop that found the stack empty (value then reads all ones).
// the user writes the capacity register via cfg_wen/cfg_wdata only while idle (unchecked).
//
// each request is accepted in idle: the accept edge reads the value and lazy-add
// memories, the commit edge in exec writes back and, for a pop, loads the result register.
// a pop result is loaded into the output register at its commit edge, then shows on m_tvalid.
// no new request is accepted until the last one has committed, set by the memory
// read then write-back on the lazy-add store.
// a stalled result waits in the output register; pushes and increments go on,
// a later pop holds in its write-back cycle until the result is taken.
// reset clears the entry count and sets capacity to 1024; memories need no clearing.
module bounded_stack_with_bottom_increment
#(
    parameter int STACK_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // push_value, bottom_count, add_amount
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // popped_value
    output logic [0:0]  m_tuser,   // was_empty
    input  logic        cfg_wen,
    input  logic [10:0] cfg_wdata  // capacity
);

    bsbi_pkg::bsbi_cmd_t    cmd;
    bsbi_pkg::bsbi_status_t status;
    logic signed [31:0]     popped_value;
    logic                   was_empty;

    bsbi_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bsbi_datapath
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .req_type     (s_tuser),
        .push_value   (s_tdata[31:0]),
        .bottom_count (s_tdata[47:32]),
        .add_amount   (s_tdata[79:48]),
        .popped_value (popped_value),
        .was_empty    (was_empty)
    );

    assign m_tdata    = popped_value;
    assign m_tuser[0] = was_empty;

endmodule

// ----- rtl/core/bsbi_checker.sv -----
// port-level checks for the bounded stack with bottom increment
// depends on bounded_stack_with_bottom_increment (bound below)
module bsbi_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // result is held while the receiver stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one request in flight: busy the cycle after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // a fresh result follows an accepted request, through the exec state and the output register
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without matching request");

    // empty pop reads all ones
    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'hFFFF_FFFF)
        else $error("empty pop value wrong");

endmodule

bind bounded_stack_with_bottom_increment bsbi_checker u_bsbi_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- sim/tb_top.sv -----
// self-checking testbench for the bounded stack with bottom increment
// depends on bsbi_pkg and bounded_stack_with_bottom_increment; predicts every pop in a
// lazy-add stack model and checks the m_ stream in order across several capacity settings
module tb_top;

    localparam int DEPTH = 1024;
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [bsbi_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [bsbi_pkg::REQ_W-1:0]  kind;
        logic [bsbi_pkg::DATA_W-1:0] value;
        logic [bsbi_pkg::KCNT_W-1:0] count;
        logic [bsbi_pkg::DATA_W-1:0] amount;
        bit                          hold_for_drain;
    } stack_req_t;

    typedef struct {
        logic [bsbi_pkg::DATA_W-1:0] value;
        logic                        empty;
    } pop_result_t;

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [79:0]                s_tdata   = '0;
    logic [1:0]                 s_tuser   = '0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [31:0]                m_tdata;
    logic [0:0]                 m_tuser;
    logic                       cfg_wen   = 1'b0;
    logic [bsbi_pkg::CAP_W-1:0] cfg_wdata = '0;

    stack_req_t  pending_reqs[$];
    pop_result_t expected_pops[$];
    stack_req_t  req_on_bus;

    // stack model
    logic [bsbi_pkg::DATA_W-1:0] slot_value [DEPTH];
    logic [bsbi_pkg::DATA_W-1:0] slot_lazy  [DEPTH];
    int                          stack_used;
    logic [bsbi_pkg::CAP_W-1:0]  capacity_reg;

    // shadow count used while generating stimulus
    int gen_used;
    int gen_limit;

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;

    bounded_stack_with_bottom_increment #(
        .STACK_DEPTH (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void advance_stack_model(stack_req_t r);
        int          lim;
        int          n;
        int          top;
        logic [31:0] pend;
        pop_result_t res;
        case (r.kind)
            bsbi_pkg::REQ_PUSH:
            begin
                lim = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
                if (stack_used < lim)
                begin
                    slot_value[IDX_W'(stack_used)] = r.value;
                    slot_lazy[IDX_W'(stack_used)]  = '0;
                    stack_used++;
                end
            end
            bsbi_pkg::REQ_POP:
            begin
                if (stack_used == 0)
                begin
                    res.value = bsbi_pkg::EMPTY_WORD;
                    res.empty = 1'b1;
                end
                else
                begin
                    top       = stack_used - 1;
                    pend      = slot_lazy[IDX_W'(top)];
                    res.value = slot_value[IDX_W'(top)] + pend;
                    res.empty = 1'b0;
                    if (top > 0)
                        slot_lazy[IDX_W'(top - 1)] = slot_lazy[IDX_W'(top - 1)] + pend;
                    slot_lazy[IDX_W'(top)] = '0;
                    stack_used             = top;
                end
                expected_pops.push_back(res);
            end
            bsbi_pkg::REQ_INCR:
            begin
                n = (r.count < stack_used) ? r.count : stack_used;
                if (n > 0)
                    slot_lazy[IDX_W'(n - 1)] = slot_lazy[IDX_W'(n - 1)] + r.amount;
            end
            default: ;
        endcase
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                advance_stack_model(req_on_bus);
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() != 0
                    && $urandom_range(0, 99) >= send_idle_pct
                    && !(pending_reqs[0].hold_for_drain && expected_pops.size() != 0))
                begin
                    req_on_bus = pending_reqs.pop_front();
                    s_tvalid   <= 1'b1;
                    s_tdata    <= {req_on_bus.amount, req_on_bus.count, req_on_bus.value};
                    s_tuser    <= req_on_bus.kind;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        pop_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_pops.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected pop transaction: value=%h empty=%b",
                                 m_tdata, m_tuser[0]);
                end
                else
                begin
                    want = expected_pops.pop_front();
                    if (m_tdata !== want.value || m_tuser[0] !== want.empty)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("pop mismatch: expected %h empty %b, actual %h empty %b",
                                     want.value, want.empty, m_tdata, m_tuser[0]);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    function automatic void queue_req(input logic [1:0] kind, input logic [31:0] value,
                                      input logic [15:0] count, input logic [31:0] amount,
                                      input bit hold = 1'b0);
        stack_req_t r;
        r.kind           = kind;
        r.value          = value;
        r.count          = count;
        r.amount         = amount;
        r.hold_for_drain = hold;
        if (kind == bsbi_pkg::REQ_PUSH && gen_used < gen_limit)
            gen_used++;
        else if (kind == bsbi_pkg::REQ_POP && gen_used > 0)
            gen_used--;
        pending_reqs.push_back(r);
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] random_bottom_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return 16'($urandom_range(0, 65535));
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(0, gen_used + 1));
        endcase
    endfunction

    // noise items of the unused code are extra and do not count
    task automatic queue_random(input int n, input int push_pct, input int pop_pct);
        int          done;
        int          pick;
        logic [1:0]  kind;
        done = 0;
        while (done < n)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 3)
                kind = REQ_UNUSED;
            else if (pick < push_pct)
                kind = bsbi_pkg::REQ_PUSH;
            else if (pick < push_pct + pop_pct)
                kind = bsbi_pkg::REQ_POP;
            else
                kind = bsbi_pkg::REQ_INCR;
            queue_req(kind, random_word(), random_bottom_count(), random_word());
            if (kind != REQ_UNUSED)
                done++;
        end
    endtask

    task automatic write_capacity(input logic [bsbi_pkg::CAP_W-1:0] cap);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_wen      <= 1'b0;
        capacity_reg = cap;
        gen_limit    = (cap > DEPTH) ? DEPTH : cap;
    endtask

    task automatic wait_until_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_pops.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    initial
    begin
        stack_used    = 0;
        capacity_reg  = bsbi_pkg::CAP_RESET;
        gen_used      = 0;
        gen_limit     = DEPTH;
        error_count   = 0;
        set_idling(19, 53);
        wait (rst_n === 1'b1);
        @(posedge clk);

        // directed: empty cases, extreme values, lazy adds passed down on pop
        queue_req(bsbi_pkg::REQ_POP,  '0,            16'd0,    '0);
        queue_req(bsbi_pkg::REQ_INCR, '0,            16'd5,    32'd7);
        queue_req(bsbi_pkg::REQ_PUSH, 32'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_req(bsbi_pkg::REQ_PUSH, 32'h8000_0000, 16'd0,    '0);
        queue_req(bsbi_pkg::REQ_PUSH, 32'hFFFF_FFFF, 16'd0,    '0);
        queue_req(bsbi_pkg::REQ_PUSH, 32'h0,         16'd0,    '0);
        queue_req(bsbi_pkg::REQ_INCR, '0,            16'd0,    32'd100);
        queue_req(bsbi_pkg::REQ_INCR, '0,            16'd2,    32'd1);
        queue_req(bsbi_pkg::REQ_INCR, '0,            16'hFFFF, 32'h7FFF_FFFF);
        queue_req(bsbi_pkg::REQ_INCR, '0,            16'd3,    32'h8000_0000);
        queue_req(REQ_UNUSED,         32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_req(bsbi_pkg::REQ_POP,  '0,            16'd0,    '0);
        queue_req(bsbi_pkg::REQ_POP,  32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_req(bsbi_pkg::REQ_PUSH, 32'h1234_5678, 16'd0,    '0);
        queue_req(bsbi_pkg::REQ_INCR, '0,            16'd4,    32'hFFFF_FFFF);
        queue_req(bsbi_pkg::REQ_POP,  '0,            16'd0,    '0);
        queue_req(bsbi_pkg::REQ_POP,  '0,            16'd0,    '0);
        queue_req(bsbi_pkg::REQ_POP,  '0,            16'd0,    '0);
        queue_req(bsbi_pkg::REQ_POP,  '0,            16'd0,    '0);
        queue_req(bsbi_pkg::REQ_POP,  '0,            16'd0,    '0);
        queue_req(bsbi_pkg::REQ_INCR, '0,            16'hFFFF, 32'h1);
        wait_until_idle();

        write_capacity(11'd3);
        queue_random(20, 45, 35);
        wait_until_idle();

        write_capacity(11'd0);
        queue_random(10, 40, 40);
        wait_until_idle();

        set_idling(53, 19);
        write_capacity(11'd1);
        queue_random(15, 45, 35);
        wait_until_idle();

        write_capacity(11'd17);
        queue_random(12, 55, 25);
        queue_req(bsbi_pkg::REQ_POP, '0, 16'd0, '0, 1'b1);
        queue_random(12, 45, 35);
        wait_until_idle();

        // fill to the full depth with a capacity beyond it
        write_capacity(11'd2047);
        while (gen_used < DEPTH)
            queue_random(1, 97, 0);
        queue_random(10, 85, 0);
        wait_until_idle();

        set_idling(0, 0);
        write_capacity(11'd1024);
        queue_random(20, 50, 40);
        wait_until_idle();

        write_capacity(11'd1023);
        queue_random(20, 45, 40);
        wait_until_idle();

        if (expected_pops.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
